// ----- design/stwa_pkg.sv -----
// Shared types and constants for the sliding time-window average block.
package stwa_pkg;

  localparam int TIME_W      = 32;
  localparam int VAL_W       = 32;
  localparam int SUM_W       = 40;
  localparam int AVG_W       = 32;
  localparam int COUNT_OUT_W = 9;
  localparam int MEM_W       = TIME_W + VAL_W;
  localparam int DIV_STEPS   = SUM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(60);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the input beat
    logic rd_en;      // read the oldest entry
    logic expire;     // drop the oldest entry
    logic append;     // append the captured sample if it is an add and the ring is not full
    logic div_start;  // seed the divider
    logic div_step;   // one quotient bit
    logic out_load;   // load the result register
  } stwa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;       // no samples held
    logic expire_hit;  // oldest entry read back is too old
  } stwa_sts_t;

endpackage

// ----- design/stwa_in_if.sv -----
// Input channel: one sample or query beat.
interface stwa_in_if
  import stwa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TIME_W-1:0] now_seconds;
  logic [VAL_W-1:0]  sample_value;

  modport source (output valid, kind, now_seconds, sample_value, input ready);
  modport sink   (input valid, kind, now_seconds, sample_value, output ready);
endinterface

// ----- design/stwa_out_if.sv -----
// Result channel: count, average and refusal flag.
interface stwa_out_if
  import stwa_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [COUNT_OUT_W-1:0] sample_count;
  logic [AVG_W-1:0]       window_average;
  logic                   add_refused;

  modport source (output valid, sample_count, window_average, add_refused, input ready);
  modport sink   (input valid, sample_count, window_average, add_refused, output ready);
endinterface

// ----- design/stwa_datapath.sv -----
// Datapath: sample store, ring pointers, running sum, serial divider, result register.
module stwa_datapath
  import stwa_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  stwa_cmd_t              cmd,
  output stwa_sts_t              sts,
  input  logic                   in_kind,
  input  logic [TIME_W-1:0]      in_now_seconds,
  input  logic [VAL_W-1:0]       in_sample_value,
  input  logic                   cfg_wr_en,
  input  logic [TIME_W-1:0]      cfg_wr_data,
  output logic [COUNT_OUT_W-1:0] out_sample_count,
  output logic [AVG_W-1:0]       out_window_average,
  output logic                   out_add_refused
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

  logic [MEM_W-1:0] mem [QUEUE_DEPTH];

  logic [TIME_W-1:0]      window_r, window_nxt;
  logic [PW-1:0]          oldest_r, oldest_nxt;
  logic [PW-1:0]          next_free_r, next_free_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic                   kind_r;
  logic [TIME_W-1:0]      now_r;
  logic [VAL_W-1:0]       value_r;
  logic [MEM_W-1:0]       rd_data_r;
  logic                   refused_r, refused_nxt;
  logic [CW-1:0]          rem_r, rem_nxt;
  logic [SUM_W-1:0]       quo_r, quo_nxt;
  logic [COUNT_OUT_W-1:0] out_count_r;
  logic [AVG_W-1:0]       out_avg_r;
  logic                   out_refused_r;

  logic [TIME_W-1:0] rd_time;
  logic [VAL_W-1:0]  rd_value;
  logic [TIME_W-1:0] age;
  logic              full;
  logic              do_add;
  logic [CW:0]       rem_sh;
  logic              div_ge;
  logic [CW:0]       rem_sub;

  assign rd_time  = rd_data_r[MEM_W-1:VAL_W];
  assign rd_value = rd_data_r[VAL_W-1:0];
  assign age      = now_r - rd_time;
  assign full     = (count_r == FULL_CNT);
  assign do_add   = cmd.append & kind_r & ~full;

  assign sts.empty      = (count_r == '0);
  assign sts.expire_hit = (age > window_r);

  // Restoring division: one quotient bit per step
  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, count_r});
  assign rem_sub = rem_sh - {1'b0, count_r};

  // Next-state logic for pointers, count, sum and divider
  always_comb begin
    window_nxt    = window_r;
    oldest_nxt    = oldest_r;
    next_free_nxt = next_free_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    refused_nxt   = refused_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    if (cfg_wr_en) begin
      window_nxt = cfg_wr_data;
    end
    if (cmd.expire) begin
      sum_nxt    = sum_r - SUM_W'(rd_value);
      count_nxt  = count_r - CW'(1);
      oldest_nxt = (oldest_r == LAST_SLOT) ? '0 : oldest_r + PW'(1);
    end
    if (cmd.append) begin
      refused_nxt = kind_r & full;
    end
    if (do_add) begin
      sum_nxt       = sum_r + SUM_W'(value_r);
      count_nxt     = count_r + CW'(1);
      next_free_nxt = (next_free_r == LAST_SLOT) ? '0 : next_free_r + PW'(1);
    end
    if (cmd.div_start) begin
      rem_nxt = '0;
      quo_nxt = sum_r;
    end
    if (cmd.div_step) begin
      rem_nxt = div_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], div_ge};
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RESET;
      oldest_r    <= '0;
      next_free_r <= '0;
      count_r     <= '0;
      sum_r       <= '0;
    end else begin
      window_r    <= window_nxt;
      oldest_r    <= oldest_nxt;
      next_free_r <= next_free_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
    end
  end

  // Hold payload: captured beat, divider, result
  always_ff @(posedge clk) begin
    refused_r <= refused_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    if (cmd.load) begin
      kind_r  <= in_kind;
      now_r   <= in_now_seconds;
      value_r <= in_sample_value;
    end
    if (cmd.out_load) begin
      out_count_r   <= COUNT_OUT_W'(count_r);
      out_avg_r     <= (count_r == '0) ? '0 : quo_r[AVG_W-1:0];
      out_refused_r <= refused_r;
    end
  end

  // Sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_add) begin
      mem[next_free_r] <= {now_r, value_r};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[oldest_r];
    end
  end

  assign out_sample_count   = out_count_r;
  assign out_window_average = out_avg_r;
  assign out_add_refused    = out_refused_r;

endmodule

// ----- design/stwa_ctrl.sv -----
// Controller: sequences capture, expiry walk, append, division and result handoff.
module stwa_ctrl
  import stwa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  input  stwa_sts_t sts,
  output logic      in_ready,
  output logic      out_valid,
  output stwa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_APPEND,
    S_DIV_INIT,
    S_DIV,
    S_DONE
  } state_t;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free = ~out_valid_r | out_ready;

  // Decode commands and next state
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (sts.empty) begin
          state_nxt = S_APPEND;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.expire_hit) begin
          cmd.expire = 1'b1;
          state_nxt  = S_READ;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_start = 1'b1;
        step_nxt      = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + DIV_CNT_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, step count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/sliding_time_window_average.sv -----
// Top level of the sliding time-window average block.
//
// Each input beat carries the current time; the block walks the oldest end of
// its sample ring, dropping every entry whose age exceeds window_seconds, then
// appends the beat's value when kind is add (refusing it when the ring holds
// QUEUE_DEPTH samples), and returns the held count and the integer average of
// the held values. Each expired entry costs a memory read and a compare/drop
// step on the single ring read port, and the average comes from a 40-step
// restoring divider, one quotient bit per cycle. The block is ready for the
// next beat in the cycle after the result register loads. A new beat is
// accepted while the previous result still waits in the output register. The
// sample store has no reset and no clearing pass; only entries that were
// written are ever read. window_seconds resets to 60 and is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while the block is
// idle, which the block itself does not enforce.
module sliding_time_window_average
  import stwa_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  stwa_in_if.sink           in_bus,
  stwa_out_if.source        out_bus,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data
);

  stwa_cmd_t cmd;
  stwa_sts_t sts;

  // Sequence one beat at a time
  stwa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .cmd       (cmd)
  );

  // Store, sum and divide
  stwa_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_bus.kind),
    .in_now_seconds     (in_bus.now_seconds),
    .in_sample_value    (in_bus.sample_value),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_sample_count   (out_bus.sample_count),
    .out_window_average (out_bus.window_average),
    .out_add_refused    (out_bus.add_refused)
  );

endmodule

// ----- tb/sliding_time_window_average_tb.sv -----
// Testbench for the sliding time-window average block: scoreboard with a predictor, random stimulus.
module sliding_time_window_average_tb;
  import stwa_pkg::*;

  localparam int DEPTH       = 256;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 12;
  localparam int LONG_HOLD   = 700;
  localparam int STALL_LIMIT = 8000;
  localparam int DRAIN_CYCLES = 600;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_ADD   = 1'b1;

  localparam logic [TIME_W-1:0] WINDOW_ZERO = '0;
  localparam logic [TIME_W-1:0] WINDOW_MAX  = '1;

  typedef struct {
    logic [COUNT_OUT_W-1:0] count;
    logic [AVG_W-1:0]       average;
    logic                   refused;
  } window_result_t;

  // Track the sample ring and predict count, average and refusal per beat
  class window_scoreboard;
    logic [TIME_W-1:0] window;
    logic [TIME_W-1:0] times  [DEPTH];
    logic [VAL_W-1:0]  values [DEPTH];
    int unsigned       oldest;
    int unsigned       next_free;
    int unsigned       held;
    logic [SUM_W-1:0]  sum;
    window_result_t    expected [$];
    int                errors;

    function new();
      window    = WINDOW_RESET;
      oldest    = 0;
      next_free = 0;
      held      = 0;
      sum       = '0;
      errors    = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // Expire from the oldest end, append, then work out the average
    function void note_input(logic kind, logic [TIME_W-1:0] now, logic [VAL_W-1:0] val);
      window_result_t    res;
      logic [TIME_W-1:0] age;
      logic [SUM_W-1:0]  quot;
      bit                young;
      young = 1'b0;
      while (held > 0 && !young) begin
        age = now - times[oldest];
        if (age <= window) begin
          young = 1'b1;
        end else begin
          sum    = sum - SUM_W'(values[oldest]);
          held   = held - 1;
          oldest = (oldest + 1) % DEPTH;
        end
      end
      res.refused = 1'b0;
      if (kind == KIND_ADD) begin
        if (held >= DEPTH) begin
          res.refused = 1'b1;
        end else begin
          times[next_free]  = now;
          values[next_free] = val;
          next_free = (next_free + 1) % DEPTH;
          held      = held + 1;
          sum       = sum + SUM_W'(val);
        end
      end
      quot = (held != 0) ? sum / SUM_W'(held) : '0;
      res.count   = COUNT_OUT_W'(held);
      res.average = quot[AVG_W-1:0];
      expected.push_back(res);
    endfunction

    // Compare one result beat with the oldest prediction
    function void check_result(logic [COUNT_OUT_W-1:0] count, logic [AVG_W-1:0] average,
                               logic refused);
      window_result_t exp_res;
      if (expected.size() == 0) begin
        $error("result beat with nothing predicted: count %0d average %0d refused %0b",
               count, average, refused);
        errors++;
      end else begin
        exp_res = expected.pop_front();
        if (count !== exp_res.count) begin
          $error("sample_count: expected %0d, actual %0d", exp_res.count, count);
          errors++;
        end
        if (average !== exp_res.average) begin
          $error("window_average: expected %0d, actual %0d", exp_res.average, average);
          errors++;
        end
        if (refused !== exp_res.refused) begin
          $error("add_refused: expected %0b, actual %0b", exp_res.refused, refused);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [TIME_W-1:0] cfg_wr_data;
  logic [TIME_W-1:0] clock_now;
  bit                idle_on;
  bit                long_hold_req;
  window_scoreboard  sb;

  stwa_in_if  in_bus ();
  stwa_out_if out_bus ();

  sliding_time_window_average #(
    .QUEUE_DEPTH (DEPTH)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Offer one beat, optionally after a gap, and hold it until accepted
  task automatic send_beat(input logic kind, input logic [TIME_W-1:0] now,
                           input logic [VAL_W-1:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.kind         <= kind;
    in_bus.now_seconds  <= now;
    in_bus.sample_value <= val;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_input(kind, now, val);
  endtask

  // Drop valid and wait for every predicted result
  task automatic quiesce();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write the window register once the block is idle
  task automatic write_window(input logic [TIME_W-1:0] w);
    quiesce();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.window = w;
  endtask

  function automatic logic [VAL_W-1:0] pick_value(input int full_pct);
    if ($urandom_range(0, 99) < full_pct) return '1;
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return VAL_W'($urandom_range(0, 255));
      2:       return '0;
      default: return VAL_W'($urandom_range(0, 1000000));
    endcase
  endfunction

  // Random beats: time mostly creeps forward, sometimes jumps anywhere
  task automatic run_random(input int count, input int add_pct, input int max_step,
                            input int jump_pct, input int full_pct);
    logic kind;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < jump_pct) clock_now = $urandom();
      else clock_now = clock_now + TIME_W'($urandom_range(0, max_step));
      kind = ($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_QUERY;
      send_beat(kind, clock_now, pick_value(full_pct));
    end
  endtask

  // Result side: check accepted beats, stall in bursts or one long hold
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        sb.check_result(out_bus.sample_count, out_bus.window_average, out_bus.add_refused);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 18);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.kind         <= KIND_QUERY;
    in_bus.now_seconds  <= '0;
    in_bus.sample_value <= '0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset window: empty query, edges of age, time going back, wrap
    send_beat(KIND_QUERY, 32'd0, 32'd0);
    send_beat(KIND_ADD, 32'd0, 32'd0);
    send_beat(KIND_ADD, 32'd10, 32'hFFFF_FFFF);
    send_beat(KIND_ADD, 32'd60, 32'd1);
    send_beat(KIND_QUERY, 32'd61, 32'd0);
    send_beat(KIND_QUERY, 32'd5, 32'd0);
    send_beat(KIND_QUERY, 32'd5, 32'd0);
    send_beat(KIND_ADD, 32'hFFFF_FFFF, 32'h8000_0000);
    send_beat(KIND_ADD, 32'h0000_003B, 32'h7FFF_FFFF);
    send_beat(KIND_QUERY, 32'h0000_003C, 32'h1234_5678);
    send_beat(KIND_ADD, 32'h1234_5678, 32'h5555_5555);
    send_beat(KIND_ADD, 32'h1234_5678, 32'hAAAA_AAAA);
    send_beat(KIND_QUERY, 32'hEDCB_A987, 32'hFFFF_FFFF);

    // Zero window: same second holds, next second expires
    write_window(WINDOW_ZERO);
    send_beat(KIND_ADD, 32'd100, 32'd7);
    send_beat(KIND_ADD, 32'd100, 32'd9);
    send_beat(KIND_QUERY, 32'd101, 32'd0);

    // Widest window: the largest age still holds
    write_window(WINDOW_MAX);
    send_beat(KIND_ADD, 32'd0, 32'd3);
    send_beat(KIND_QUERY, 32'hFFFF_FFFF, 32'd0);

    // Default window with a long result-side hold in the middle
    write_window(WINDOW_RESET);
    clock_now = $urandom();
    run_random(120, 70, 2, 3, 5);
    long_hold_req = 1'b1;
    run_random(200, 70, 2, 3, 5);

    // Zero window, slow clock
    write_window(WINDOW_ZERO);
    run_random(200, 70, 1, 2, 5);

    // Widest window: fill the store, refuse adds, push wide sums
    write_window(WINDOW_MAX);
    run_random(350, 90, 3, 0, 60);

    // Expire the full store in one beat
    write_window(WINDOW_ZERO);
    clock_now = clock_now + 32'd1;
    send_beat(KIND_QUERY, clock_now, $urandom());

    // Short random window; pause the sender midway until all results drain
    write_window(TIME_W'($urandom_range(1, 40)));
    run_random(125, 65, 3, 4, 10);
    quiesce();
    run_random(125, 65, 3, 4, 10);

    // Arbitrary window, arbitrary times
    write_window($urandom());
    run_random(160, 60, 1000, 15, 10);

    // Last part without idling on either side
    write_window(TIME_W'(20));
    idle_on = 1'b0;
    run_random(100, 70, 2, 3, 10);

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
